@@ rtl/srjs_pkg.sv @@
// ----------------------------------------------------------------------------
// srjs_pkg
// Types and constants shared by the scan range jump segmenter modules.
// ----------------------------------------------------------------------------
package srjs_pkg;

  localparam int RANGE_W    = 18;
  localparam int THR_W      = 18;
  localparam int MINPT_W    = 13;
  localparam int ID_W       = 13;
  localparam int FIRST_W    = 12;
  localparam int COUNT_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINPT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PASS  = 2'd2;

  localparam logic [THR_W-1:0]   THR_RST   = 18'd1000;
  localparam logic [MINPT_W-1:0] MINPT_RST = 13'd1;

  typedef enum logic [1:0] {
    JUMP_NONE = 2'd0,
    JUMP_RISE = 2'd1,
    JUMP_FALL = 2'd2
  } jump_t;

  typedef enum logic [1:0] {
    CLS_BACK    = 2'd0,
    CLS_FORE    = 2'd1,
    CLS_EITHER  = 2'd2,
    CLS_UNKNOWN = 2'd3
  } cls_t;

  typedef struct packed {
    logic [THR_W-1:0]   thr;
    logic [MINPT_W-1:0] min_pts;
    logic               pass_all;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    cls_t               cls;
    logic [FIRST_W-1:0] first;
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } res_t;

  // up to two results caused by one item, r0 goes out first
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } pair_t;

endpackage

@@ rtl/scan_range_jump_segmenter.sv @@
// ----------------------------------------------------------------------------
// scan_range_jump_segmenter
// Splits a scan at range jumps and emits one descriptor per foreground segment,
// or per segment when pass_all is set.
// Path: an accepted item passes the input register, then the result buffer.
// Throughput: 1 item per cycle while out_tready is high; an item that yields
//   two results holds the input while the result buffer drains.
// Reset (rst_n low, synchronous): config returns to defaults, scan state
//   and the result buffer clear.
module scan_range_jump_segmenter #(
  parameter int MAX_POINTS = 4096,
  parameter int RANGE_BITS = 18
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,  // range_mm
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [39:0]                     out_tdata, // segment_id, first_index, point_count
  output logic [2:0]                      out_tuser, // segment_class, index_overflow
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [srjs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srjs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import srjs_pkg::*;

  cfg_t  cfg_r;
  logic  ld_valid, ld_ready;
  pair_t ld_pair;
  res_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr      <= THR_RST;
      cfg_r.min_pts  <= MINPT_RST;
      cfg_r.pass_all <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THR:   cfg_r.thr      <= cfg_wdata[THR_W-1:0];
        REG_MINPT: cfg_r.min_pts  <= cfg_wdata[MINPT_W-1:0];
        REG_PASS:  cfg_r.pass_all <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  srjs_seg #(
    .MAX_POINTS (MAX_POINTS),
    .RANGE_BITS (RANGE_BITS)
  ) u_seg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_range (in_tdata[RANGE_W-1:0]),
    .in_end   (in_tlast),
    .ld_ready (ld_ready),
    .ld_valid (ld_valid),
    .ld_pair  (ld_pair)
  );

  srjs_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_valid  (ld_valid),
    .ld_pair   (ld_pair),
    .ld_ready  (ld_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, res.count, res.first, res.id};
  assign out_tuser = {res.ovf, res.cls};

endmodule

@@ rtl/srjs_seg.sv @@
// ----------------------------------------------------------------------------
// srjs_seg
// Input register, per-scan state and jump classification; hands one result
// pair per item to the output buffer.
// ----------------------------------------------------------------------------
module srjs_seg #(
  parameter int MAX_POINTS = 4096,
  parameter int RANGE_BITS = 18
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  srjs_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [srjs_pkg::RANGE_W-1:0] in_range,
  input  logic                         in_end,
  input  logic                         ld_ready,
  output logic                         ld_valid,
  output srjs_pkg::pair_t              ld_pair
);
  import srjs_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int RNG_W = (RANGE_BITS < RANGE_W) ? RANGE_BITS : RANGE_W;
  localparam int CMP_W = (CNT_W > MINPT_W) ? CNT_W : MINPT_W;
  localparam int DIF_W = THR_W + 1;
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_POINTS - 1);

  logic             vld_r;
  logic [RNG_W-1:0] rng_r;
  logic             end_r;

  logic [RNG_W-1:0] prev_r,  prev_nxt;
  jump_t            open_r,  open_nxt;
  logic [CNT_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0] idx_r,   idx_nxt;
  logic [CNT_W-1:0] id_r,    id_nxt;
  logic             ovf_r,   ovf_nxt;

  logic             adv;
  logic [DIF_W-1:0] prev_x, cur_x, thr_x;
  logic             rise, fall, full, jump;
  jump_t            cur;
  cls_t             jcls, fcls;
  logic [CNT_W-1:0] jcount, start_new, id_new, last, fcount;
  logic             ovf_new;

  assign adv      = vld_r && ld_ready;
  assign in_ready = !vld_r || adv;
  assign ld_valid = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rng_r <= in_range[RNG_W-1:0];
      end_r <= in_end;
    end
  end

  always_comb begin
    prev_x = DIF_W'(prev_r);
    cur_x  = DIF_W'(rng_r);
    thr_x  = DIF_W'(cfg.thr);
    rise   = cur_x > (prev_x + thr_x);
    fall   = prev_x > (cur_x + thr_x);
    cur    = rise ? JUMP_RISE : (fall ? JUMP_FALL : JUMP_NONE);
    full   = idx_r >= MAX_CNT;
    jump   = !full && (idx_r != '0) && (cur != JUMP_NONE);
    jcount = idx_r - start_r;

    if (open_r == JUMP_NONE) begin
      jcls = CLS_UNKNOWN;
    end else if (cur == open_r) begin
      jcls = CLS_EITHER;
    end else if (cur == JUMP_FALL) begin
      jcls = CLS_BACK;
    end else if (CMP_W'(jcount) >= CMP_W'(cfg.min_pts)) begin
      jcls = CLS_FORE;
    end else begin
      jcls = CLS_EITHER;
    end

    if (full) begin
      start_new = start_r;
    end else if (idx_r == '0) begin
      start_new = '0;
    end else if (jump) begin
      start_new = idx_r;
    end else begin
      start_new = start_r;
    end
    id_new  = jump ? id_r + 1'b1 : id_r;
    last    = full ? LAST_CNT : idx_r;
    fcls    = (last == '0) ? CLS_BACK : CLS_UNKNOWN;
    fcount  = last - start_new + 1'b1;
    ovf_new = ovf_r | full;
  end

  always_comb begin
    ld_pair.v0       = jump && (cfg.pass_all || (jcls == CLS_FORE));
    ld_pair.r0.id    = ID_W'(id_r);
    ld_pair.r0.cls   = jcls;
    ld_pair.r0.first = FIRST_W'(start_r);
    ld_pair.r0.count = COUNT_W'(jcount);
    ld_pair.r0.ovf   = ovf_r;
    ld_pair.v1       = end_r && (cfg.pass_all || (fcls == CLS_FORE));
    ld_pair.r1.id    = ID_W'(id_new);
    ld_pair.r1.cls   = fcls;
    ld_pair.r1.first = FIRST_W'(start_new);
    ld_pair.r1.count = COUNT_W'(fcount);
    ld_pair.r1.ovf   = ovf_new;
  end

  always_comb begin
    prev_nxt  = prev_r;
    open_nxt  = open_r;
    start_nxt = start_r;
    idx_nxt   = idx_r;
    id_nxt    = id_r;
    ovf_nxt   = ovf_r;
    if (adv) begin
      if (end_r) begin
        prev_nxt  = '0;
        open_nxt  = JUMP_NONE;
        start_nxt = '0;
        idx_nxt   = '0;
        id_nxt    = '0;
        ovf_nxt   = 1'b0;
      end else if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        prev_nxt  = rng_r;
        idx_nxt   = idx_r + 1'b1;
        start_nxt = start_new;
        id_nxt    = id_new;
        if (idx_r == '0) begin
          open_nxt = JUMP_NONE;
        end else if (jump) begin
          open_nxt = cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      open_r  <= JUMP_NONE;
      start_r <= '0;
      idx_r   <= '0;
      id_r    <= '0;
      ovf_r   <= 1'b0;
    end else begin
      prev_r  <= prev_nxt;
      open_r  <= open_nxt;
      start_r <= start_nxt;
      idx_r   <= idx_nxt;
      id_r    <= id_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

@@ rtl/srjs_obuf.sv @@
// ----------------------------------------------------------------------------
// srjs_obuf
// Result pair buffer; drains up to two results per item, marks the last one.
// ----------------------------------------------------------------------------
module srjs_obuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ld_valid,
  input  srjs_pkg::pair_t ld_pair,
  output logic            ld_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output srjs_pkg::res_t  out_res,
  output logic            out_last
);
  import srjs_pkg::*;

  logic v0_r, v0_nxt;
  logic v1_r, v1_nxt;
  res_t r0_r, r1_r;
  logic take;

  assign out_valid = v0_r | v1_r;
  assign out_res   = v0_r ? r0_r : r1_r;
  assign out_last  = v0_r ? !v1_r : 1'b1;
  assign take      = out_valid && out_ready;
  assign ld_ready  = !out_valid || (take && !(v0_r && v1_r));

  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    if (take) begin
      if (v0_r) begin
        v0_nxt = 1'b0;
      end else begin
        v1_nxt = 1'b0;
      end
    end
    if (ld_valid) begin
      v0_nxt = ld_pair.v0;
      v1_nxt = ld_pair.v1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid) begin
      r0_r <= ld_pair.r0;
      r1_r <= ld_pair.r1;
    end
  end

endmodule
